FILE: design/dtfn_pkg.sv
// Shared types and codes of the device table find-next unit.
package dtfn_pkg;

   localparam logic [1:0] OP_APPEND     = 2'd0;
   localparam logic [1:0] OP_FIND_ID    = 2'd1;
   localparam logic [1:0] OP_FIND_CLASS = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 96;

   typedef struct packed {
      logic [7:0]  irq_pin;
      logic [7:0]  irq_line;
      logic [7:0]  prog_interface;
      logic [7:0]  subclass_code;
      logic [7:0]  class_code;
      logic [15:0] device_id;
      logic [15:0] vendor_id;
      logic [2:0]  function_number;
      logic [4:0]  slot_number;
      logic [7:0]  bus_number;
   } dtfn_rec_type;

   typedef struct packed {
      logic [6:0]  pad;
      logic [7:0]  irq_pin;
      logic [7:0]  irq_line;
      logic [7:0]  prog_interface;
      logic [7:0]  subclass_code;
      logic [7:0]  class_code;
      logic [15:0] device_id;
      logic [15:0] vendor_id;
      logic [2:0]  function_number;
      logic [4:0]  slot_number;
      logic [7:0]  bus_number;
      logic [8:0]  start_index;
   } dtfn_req_type;

   typedef struct packed {
      dtfn_rec_type rec;
      logic [7:0]   match_index;
   } dtfn_rsp_type;

endpackage

FILE: design/dtfn_store.sv
// Record memory of the device table with one write port and one registered read port.
module dtfn_store #(
   parameter int DEPTH = 256,
   parameter int IDX_W = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  dtfn_pkg::dtfn_rec_type wr_rec,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output dtfn_pkg::dtfn_rec_type rd_rec
);

   dtfn_pkg::dtfn_rec_type mem_ff [DEPTH];
   dtfn_pkg::dtfn_rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_rec = rd_rec_ff;

endmodule

FILE: design/device_table_find_next_unit.sv
// Top level of the device table: append and find-next by id or by class.
//
// An accepted append writes its record unless the table is full, then goes to
// S_DONE. A find reads one stored record per cycle through the single read port
// of the record memory and compares it in one shared comparator, from
// start_index up to the last stored record or the first hit, then goes to
// S_DONE. From S_DONE the result moves into the output register; a stalled
// output register holds it in S_DONE until rsp_tready takes the earlier result.
// The unit takes one transaction at a time; req_tready is low from acceptance
// until the result moves into the output register, which may still hold an
// earlier result waiting for rsp_tready.
module device_table_find_next_unit #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_index, bus_number, slot_number, function_number, vendor_id, device_id,
   // class_code, subclass_code, prog_interface, irq_line, irq_pin, zero fill.
   input  logic [103:0] req_tdata,
   // opcode.
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // match_index, found_bus, found_slot, found_function, found_vendor, found_device,
   // found_class, found_subclass, found_prog_interface, found_irq_line, found_irq_pin.
   output logic [95:0]  rsp_tdata,
   // status.
   output logic [1:0]   rsp_tuser
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ADDR_W = (CNT_W > 9) ? CNT_W : 9;
   localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   vld_ff, vld_in;
   logic [7:0]             cidx_ff, cidx_in;
   logic [1:0]             op_ff, op_in;
   dtfn_pkg::dtfn_req_type key_ff, key_in;
   dtfn_pkg::dtfn_rsp_type res_ff, res_in;
   logic [1:0]             res_st_ff, res_st_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dtfn_pkg::dtfn_rsp_type rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   dtfn_pkg::dtfn_req_type req;
   dtfn_pkg::dtfn_rec_type wr_rec;
   dtfn_pkg::dtfn_rec_type rd_rec;
   logic [ADDR_W-1:0]      count_a;
   logic                   req_acc;
   logic                   issue;
   logic                   hit;
   logic                   wr_en;

   assign req      = dtfn_pkg::dtfn_req_type'(req_tdata);
   assign count_a  = ADDR_W'(count_ff);
   assign req_acc  = req_tvalid && req_tready;
   assign issue    = (state_ff == S_SCAN) && (addr_ff < count_a);

   assign wr_rec.irq_pin         = req.irq_pin;
   assign wr_rec.irq_line        = req.irq_line;
   assign wr_rec.prog_interface  = req.prog_interface;
   assign wr_rec.subclass_code   = req.subclass_code;
   assign wr_rec.class_code      = req.class_code;
   assign wr_rec.device_id       = req.device_id;
   assign wr_rec.vendor_id       = req.vendor_id;
   assign wr_rec.function_number = req.function_number;
   assign wr_rec.slot_number     = req.slot_number;
   assign wr_rec.bus_number      = req.bus_number;

   always_comb begin
      if (op_ff == dtfn_pkg::OP_FIND_ID) begin
         hit = vld_ff && (rd_rec.vendor_id == key_ff.vendor_id) &&
               (rd_rec.device_id == key_ff.device_id);
      end else begin
         hit = vld_ff && (rd_rec.class_code == key_ff.class_code) &&
               (rd_rec.subclass_code == key_ff.subclass_code);
      end
   end

   dtfn_store #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_rec  (wr_rec),
      .rd_en   (issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_rec  (rd_rec)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      vld_in       = vld_ff;
      cidx_in      = cidx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               key_in = req;
               op_in  = req_tuser;
               case (req_tuser)
                  dtfn_pkg::OP_APPEND: begin
                     res_in = '0;
                     if (count_a == DEPTH_A) begin
                        res_st_in = dtfn_pkg::ST_FULL;
                     end else begin
                        wr_en              = 1'b1;
                        count_in           = count_ff + CNT_W'(1);
                        res_in.match_index = count_a[7:0];
                        res_st_in          = dtfn_pkg::ST_OK;
                     end
                     state_in = S_DONE;
                  end
                  dtfn_pkg::OP_FIND_ID, dtfn_pkg::OP_FIND_CLASS: begin
                     addr_in  = ADDR_W'(req.start_index);
                     vld_in   = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in    = '0;
                     res_st_in = dtfn_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            vld_in  = issue;
            cidx_in = addr_ff[7:0];
            if (issue) begin
               addr_in = addr_ff + ADDR_W'(1);
            end
            if (hit) begin
               res_in.rec         = rd_rec;
               res_in.match_index = cidx_ff;
               res_st_in          = dtfn_pkg::ST_OK;
               state_in           = S_DONE;
            end else if (!issue) begin
               res_in    = '0;
               res_st_in = dtfn_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_user_in  = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      cidx_ff     <= cidx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: design/dtfn_checker.sv
// Port-level assertions for the device table find-next unit and their bind.
module dtfn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result holds its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result changed while stalled.");

   // The unit works on one transaction at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Input accepted while a transaction is in progress.");

   // Status carries only the three defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == dtfn_pkg::ST_OK) || (rsp_tuser == dtfn_pkg::ST_NOT_FOUND) ||
                     (rsp_tuser == dtfn_pkg::ST_FULL))
      else $error("Undefined status code.");

   // A miss or a full table returns an all-zero record and index.
   a_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == dtfn_pkg::ST_NOT_FOUND) || (rsp_tuser == dtfn_pkg::ST_FULL))
      |-> rsp_tdata == '0)
      else $error("Nonzero payload on a miss or a full table.");

endmodule

bind device_table_find_next_unit dtfn_checker u_dtfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
